### rtl/core/xorshift16_range_generator_assert.svh
// ----------------------------------------------------------------------------
// xorshift16 range generator assertion macros
// shared property forms for the generator's concurrent checks
// ----------------------------------------------------------------------------
`ifndef XORSHIFT16_RANGE_GENERATOR_ASSERT_SVH
`define XORSHIFT16_RANGE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define XRG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xrg same-cycle check failed");

// next-cycle implication
`define XRG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xrg next-cycle check failed");

// delayed implication
`define XRG_ASSERT_LATER2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("xrg two-cycle check failed");

`endif

### rtl/core/xrg_pkg.sv
// ----------------------------------------------------------------------------
// xrg_pkg
// types, constants and the xorshift step shared by the range generator
// ----------------------------------------------------------------------------
`default_nettype none

package xrg_pkg;

   localparam int STATE_W   = 16;
   localparam int DATA_W    = 32;
   localparam int DIV_STEPS = STATE_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(DIV_STEPS - 1);
   localparam logic [STATE_W-1:0] STATE_ONE = STATE_W'(1);

   localparam int SHIFT_A = 7;
   localparam int SHIFT_B = 9;
   localparam int SHIFT_C = 8;

   localparam logic REQ_RESEED = 1'b0;
   localparam logic REQ_DRAW   = 1'b1;

   typedef struct packed {
      logic                     req_type;
      logic [DATA_W-1:0]        seed;
      logic signed [DATA_W-1:0] low_bound;
      logic signed [DATA_W-1:0] high_bound;
   } xrg_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     div_error;
   } xrg_rsp_type;

   typedef struct packed {
      logic load_seed;
      logic start_draw;
      logic advance;
      logic div_step;
      logic load_out;
   } xrg_cmd_type;

   typedef struct packed {
      logic is_draw;
      logic span_pos;
      logic mod_zero;
   } xrg_sts_type;

   function automatic logic [STATE_W-1:0] xs_advance(input logic [STATE_W-1:0] s_in);
      logic [STATE_W-1:0] s;
      s = s_in;
      s = s ^ (s << SHIFT_A);
      s = s ^ (s >> SHIFT_B);
      s = s ^ (s << SHIFT_C);
      return s;
   endfunction

endpackage

`default_nettype wire

### rtl/core/xrg_ctrl.sv
// ----------------------------------------------------------------------------
// xrg_ctrl
// request sequencing, divider step count and result beat handshake
// ----------------------------------------------------------------------------
`default_nettype none

module xrg_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire xrg_pkg::xrg_sts_type sts,
   output xrg_pkg::xrg_cmd_type    cmd
);
   import xrg_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!sts.is_draw) begin
                  cmd.load_seed = 1'b1;
               end else begin
                  cmd.start_draw = 1'b1;
                  cmd.advance    = sts.span_pos;
                  cnt_in         = '0;
                  if (sts.span_pos && !sts.mod_zero) begin
                     state_in = ST_DIVIDE;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/xrg_dp.sv
// ----------------------------------------------------------------------------
// xrg_dp
// generator state, span checks, bit-serial remainder and result register
// ----------------------------------------------------------------------------
`default_nettype none

module xrg_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire xrg_pkg::xrg_req_type req_data,
   input  wire xrg_pkg::xrg_cmd_type cmd,
   output xrg_pkg::xrg_sts_type      sts,
   output xrg_pkg::xrg_rsp_type      rsp_data
);
   import xrg_pkg::*;

   logic [STATE_W-1:0] state_ff;
   logic [STATE_W-1:0] next_state;
   logic [DATA_W-1:0]  span;
   logic [DATA_W-1:0]  lo_ff;
   logic               err_ff;
   logic [STATE_W-1:0] rem_ff;
   logic [STATE_W-1:0] quo_ff;
   logic [STATE_W-1:0] div_ff;
   logic [STATE_W:0]   trial;
   logic [STATE_W:0]   diff;
   logic [DATA_W-1:0]  sum;
   xrg_rsp_type        out_ff;

   assign span         = req_data.high_bound - req_data.low_bound;
   assign sts.is_draw  = (req_data.req_type == REQ_DRAW);
   assign sts.span_pos = (span != '0) && !span[DATA_W-1];
   assign sts.mod_zero = (span[STATE_W-1:0] == '0);

   assign next_state = xs_advance(state_ff);

   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[STATE_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign sum   = lo_ff + {{(DATA_W-STATE_W){1'b0}}, rem_ff};

   assign rsp_data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_ONE;
      end else if (cmd.load_seed) begin
         if (req_data.seed != '0) begin
            state_ff <= req_data.seed[STATE_W-1:0];
         end else begin
            state_ff <= STATE_ONE;
         end
      end else if (cmd.advance) begin
         state_ff <= next_state;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_draw) begin
         lo_ff  <= req_data.low_bound;
         err_ff <= sts.span_pos & sts.mod_zero;
         rem_ff <= '0;
         quo_ff <= next_state;
         div_ff <= span[STATE_W-1:0];
      end else if (cmd.div_step) begin
         if (!diff[STATE_W]) begin
            rem_ff <= diff[STATE_W-1:0];
         end else begin
            rem_ff <= trial[STATE_W-1:0];
         end
         quo_ff <= {quo_ff[STATE_W-2:0], 1'b0};
      end
      if (cmd.load_out) begin
         out_ff.value     <= sum;
         out_ff.div_error <= err_ff;
      end
   end

endmodule

`default_nettype wire

### rtl/core/xorshift16_range_generator.sv
// ----------------------------------------------------------------------------
// xorshift16 range generator: reseed beats give no result, draw beats one
// normal draw: the state advances, ST_DIVIDE runs DIV_STEPS remainder steps, then
// ST_FINISH loads the result once the output is free; short draw (span not positive
// or zero low half) skips ST_DIVIDE; reseed stays in ST_IDLE; reset state 1
// ----------------------------------------------------------------------------
`default_nettype none
`include "xorshift16_range_generator_assert.svh"

module xorshift16_range_generator (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire xrg_pkg::xrg_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output xrg_pkg::xrg_rsp_type      rsp_data
);
   import xrg_pkg::*;

   xrg_cmd_type       cmd;
   xrg_sts_type       sts;
   logic              seed_beat;
   logic              flat_beat;
   logic [DATA_W-1:0] span_chk;

   xrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   xrg_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   assign span_chk  = req_data.high_bound - req_data.low_bound;
   assign seed_beat = req_valid & req_ready & (req_data.req_type == REQ_RESEED);
   assign flat_beat = req_valid & req_ready & (req_data.req_type == REQ_DRAW)
                      & ((span_chk == '0) | span_chk[DATA_W-1]);

   `XRG_ASSERT_NEXT(a_seed_no_rsp, clock, reset, seed_beat & !rsp_valid, !rsp_valid)
   `XRG_ASSERT_LATER2(a_flat_draw, clock, reset, flat_beat & !rsp_valid, rsp_valid && (rsp_data.value == $past(req_data.low_bound, 2)) && !rsp_data.div_error)
   `XRG_ASSERT_NOW(a_cmd_excl, clock, reset, 1'b1, $onehot0({cmd.load_seed, cmd.start_draw, cmd.div_step, cmd.load_out}))

endmodule

`default_nettype wire

### verif/xorshift16_range_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xorshift16 range generator testbench
// a directed table, then random reseed and draw beats, with bursty requests
// and a stalling response side; each draw is checked against its fixed table
// value or a local model of the 7/9/8 xorshift state and the 16-bit remainder
// ----------------------------------------------------------------------------

module xorshift16_range_generator_tb;

   import xrg_pkg::*;

   localparam int RANDOM_BEATS = 1225;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      xrg_req_type req;
      logic        fixed;
      xrg_rsp_type rsp;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   xrg_req_type req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   xrg_rsp_type rsp_data;

   stim_row_type stim_table[$];
   xrg_rsp_type  pending_draws[$];
   xrg_rsp_type  want;
   logic [15:0]  gen_state;
   int           error_count    = 0;
   int           accepted_count = 0;
   int           idle_cycles    = 0;
   int           burst_left     = 0;

   xorshift16_range_generator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic [15:0] step_xorshift(input logic [15:0] s);
      logic [15:0] t;
      t = s ^ {s[8:0], 7'b0};
      t = t ^ {9'b0, t[15:9]};
      t = t ^ {t[7:0], 8'b0};
      return t;
   endfunction

   task automatic predict_beat(input xrg_req_type r, output logic has_rsp,
                               output xrg_rsp_type rsp);
      logic [31:0] span;
      logic [15:0] modulus;
      logic [15:0] rem;
      has_rsp = 1'b0;
      rsp     = '0;
      if (r.req_type == REQ_RESEED) begin
         gen_state = (r.seed == 32'd0) ? STATE_ONE : r.seed[15:0];
      end else begin
         has_rsp       = 1'b1;
         span          = r.high_bound - r.low_bound;
         rsp.value     = r.low_bound;
         rsp.div_error = 1'b0;
         if (span != 32'd0 && !span[31]) begin
            gen_state = step_xorshift(gen_state);
            modulus   = span[15:0];
            if (modulus == 16'd0) begin
               rsp.div_error = 1'b1;
            end else begin
               rem       = gen_state % modulus;
               rsp.value = r.low_bound + {16'b0, rem};
            end
         end
      end
   endtask

   task automatic add_row(input logic kind, input logic [31:0] seed, input logic [31:0] lo,
                          input logic [31:0] hi, input int fixed, input logic [31:0] val,
                          input int err);
      stim_row_type row;
      row.req.req_type   = kind;
      row.req.seed       = seed;
      row.req.low_bound  = lo;
      row.req.high_bound = hi;
      row.fixed          = (fixed != 0);
      row.rsp.value      = val;
      row.rsp.div_error  = (err != 0);
      stim_table.push_back(row);
   endtask

   function automatic xrg_req_type random_req();
      xrg_req_type r;
      logic [31:0] lo;
      r.seed       = $urandom;
      r.low_bound  = $urandom;
      r.high_bound = $urandom;
      r.req_type   = ($urandom_range(0, 3) == 0) ? REQ_RESEED : REQ_DRAW;
      lo           = r.low_bound;
      if (r.req_type == REQ_RESEED) begin
         case ($urandom_range(0, 9))
            0: r.seed = '0;
            1: r.seed[15:0] = '0;
            default: ;
         endcase
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2: r.high_bound = lo + $urandom_range(1, 300);
            3, 4:    r.high_bound = lo + $urandom_range(1, 32'h7fffffff);
            5:       r.high_bound = lo + ($urandom_range(1, 32'h7fff) << 16);
            6:       r.high_bound = lo - $urandom_range(0, 300);
            7: begin
               lo = ($urandom_range(0, 1) == 0) ? 32'h80000000
                                                : 32'h7fffffff - $urandom_range(0, 200);
               r.low_bound  = lo;
               r.high_bound = lo + $urandom_range(1, 70000);
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      error_count++;
      if (error_count <= 50)
         $display("mismatch on %s at %0t: got %h, expected %h", field, $time, got, exp_val);
   endtask

   task automatic send_row(input stim_row_type row);
      int          gap;
      logic        has_rsp;
      xrg_rsp_type rsp;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (accepted_count >= 700 && accepted_count < 900)
            gap = 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= row.req;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      accepted_count++;
      predict_beat(row.req, has_rsp, rsp);
      if (has_rsp)
         pending_draws.push_back(row.fixed ? row.rsp : rsp);
   endtask

   // request side and end of run
   initial begin
      stim_row_type row;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      gen_state = STATE_ONE;

      add_row(REQ_DRAW,   32'h0,        32'h00000000, 32'h00000002, 1, 32'h00000001, 0);
      add_row(REQ_DRAW,   32'hffffffff, 32'h00000000, 32'h00000000, 1, 32'h00000000, 0);
      add_row(REQ_DRAW,   32'h0,        32'd100,      32'd100,      1, 32'd100,      0);
      add_row(REQ_DRAW,   32'h0,        32'd10,       -32'sd3,      1, 32'd10,       0);
      add_row(REQ_DRAW,   32'h0,        32'h80000000, 32'h7fffffff, 1, 32'h80000000, 0);
      add_row(REQ_DRAW,   32'h0,        32'h7fffffff, 32'h80000000, 1, 32'h7fffffff, 0);
      add_row(REQ_DRAW,   32'h0,        32'h00000000, 32'h00010000, 1, 32'h00000000, 1);
      add_row(REQ_DRAW,   32'h0,        32'h80000000, 32'h80010000, 1, 32'h80000000, 1);
      add_row(REQ_DRAW,   32'h0,        32'h00000000, 32'h7fffffff, 0, 32'h0,        0);
      add_row(REQ_DRAW,   32'h0,        32'h7fff0000, 32'h7fffffff, 0, 32'h0,        0);
      add_row(REQ_DRAW,   32'h0,        32'h80000000, 32'h8000ffff, 0, 32'h0,        0);
      add_row(REQ_DRAW,   32'h0,        32'hffffffff, 32'h00000000, 1, 32'hffffffff, 0);
      add_row(REQ_RESEED, 32'h00000000, 32'hffffffff, 32'hffffffff, 0, 32'h0,        0);
      add_row(REQ_DRAW,   32'h0,        32'h00000000, 32'h00000002, 1, 32'h00000001, 0);
      add_row(REQ_RESEED, 32'hffffffff, 32'h0,        32'h0,        0, 32'h0,        0);
      add_row(REQ_DRAW,   32'h0,        -32'sd1000,   32'd1000,     0, 32'h0,        0);
      // nonzero seed with zero low half locks the state at zero
      add_row(REQ_RESEED, 32'h00010000, 32'h0,        32'h0,        0, 32'h0,        0);
      add_row(REQ_DRAW,   32'h0,        32'd0,        32'd100,      1, 32'd0,        0);
      add_row(REQ_DRAW,   32'h0,        -32'sd5,      32'd7,        1, -32'sd5,      0);
      add_row(REQ_RESEED, 32'hffff0000, 32'h0,        32'h0,        0, 32'h0,        0);
      add_row(REQ_DRAW,   32'h0,        32'h7fffff00, 32'h7fffffff, 1, 32'h7fffff00, 0);
      add_row(REQ_RESEED, 32'h0000ffff, 32'h0,        32'h0,        0, 32'h0,        0);
      add_row(REQ_DRAW,   32'h0,        32'h00000000, 32'h80000000, 1, 32'h00000000, 0);
      add_row(REQ_RESEED, 32'h12345678, 32'h0,        32'h0,        0, 32'h0,        0);
      add_row(REQ_DRAW,   32'h0,        32'h00000000, 32'h0000ffff, 0, 32'h0,        0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i])
         send_row(stim_table[i]);
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         row.req   = random_req();
         row.fixed = 1'b0;
         row.rsp   = '0;
         send_row(row);
      end
      req_valid <= 1'b0;

      while (pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[xorshift16_range_generator] OK");
      end else begin
         $display("[xorshift16_range_generator] ERROR");
      end
      $finish;
   end

   // response side stall pattern, with one long hold-off
   initial begin
      int  cyc;
      logic held;
      cyc       = 0;
      held      = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (!held && accepted_count >= 400) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            case ((cyc / 600) % 4)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (cyc % 23) < 15;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_draws.size() == 0) begin
            report_mismatch("unexpected beat", rsp_data.value, 32'h0);
         end else begin
            want = pending_draws.pop_front();
            if (rsp_data.value !== want.value)
               report_mismatch("value", rsp_data.value, want.value);
            if (rsp_data.div_error !== want.div_error)
               report_mismatch("div_error", {31'b0, rsp_data.div_error},
                               {31'b0, want.div_error});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("[xorshift16_range_generator] ERROR");
      $finish;
   end

endmodule
